FILE: hw/rtl/mhpt_pkg.sv
// ----------------------------------------------------------------------------
// Header page tracker package
// Shared types and constants for the tracker top level and its entry cells.
// ----------------------------------------------------------------------------
package mhpt_pkg;

  // Magic words of the main stream and of a data stream, byte 0 in bits 7:0.
  localparam logic [63:0] MAIN_TAG = 64'h0078_6564_6F6E_6E41;
  localparam logic [63:0] DATA_TAG = 64'h0061_7461_4478_6E41;

  localparam int SERIAL_W = 32;
  localparam int COUNT_W  = 32;

  // Phase codes as seen on the output.
  typedef enum logic [2:0] {
    PH_NOTHING     = 3'd0,
    PH_MAIN_BEGIN  = 3'd1,
    PH_MAIN_END    = 3'd2,
    PH_ALL_HEADERS = 3'd3,
    PH_INVALID     = 3'd4
  } phase_t;

  // Scan token passed from cell to cell during a header page lookup.
  typedef struct packed {
    logic active;   // token is at this cell in this cycle
    logic fwd;      // some matching entry was decremented
    logic bad;      // some matching entry was already zero
    logic nonzero;  // some recorded count is still nonzero
  } mhpt_tok_t;

  // Append of a new data stream entry.
  typedef struct packed {
    logic                en;
    logic [SERIAL_W-1:0] serial;
    logic [COUNT_W-1:0]  count;
  } mhpt_wr_t;

endpackage

FILE: hw/rtl/mhpt_cell.sv
// ----------------------------------------------------------------------------
// Header page tracker entry cell
// Holds one stream entry and processes the scan token as it passes by.
// ----------------------------------------------------------------------------
module mhpt_cell #(
  parameter int MAX_STREAMS = 16,
  parameter int IDX         = 0
) (
  input  logic                                clk,
  input  logic                                rst,
  input  mhpt_pkg::mhpt_wr_t                  wr,
  input  logic [$clog2(MAX_STREAMS+1)-1:0]    used,
  input  logic [mhpt_pkg::SERIAL_W-1:0]       scan_serial,
  input  mhpt_pkg::mhpt_tok_t                 tok_in,
  output mhpt_pkg::mhpt_tok_t                 tok_out
);
  import mhpt_pkg::*;

  localparam int UW = $clog2(MAX_STREAMS + 1);

  logic [SERIAL_W-1:0] serial;
  logic [COUNT_W-1:0]  count;
  logic [COUNT_W-1:0]  count_after;
  logic                live;
  logic                hit;
  logic                dec;

  assign live        = UW'(IDX) < used;
  assign hit         = live && (serial == scan_serial);
  assign dec         = hit && (count != '0);
  assign count_after = dec ? count - COUNT_W'(1) : count;

  always_ff @(posedge clk) begin
    if (wr.en && used == UW'(IDX)) begin
      serial <= wr.serial;
      count  <= wr.count;
    end else if (tok_in.active) begin
      count <= count_after;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.active <= 1'b0;
    end else begin
      tok_out.active <= tok_in.active;
    end
    tok_out.fwd     <= tok_in.fwd | dec;
    tok_out.bad     <= tok_in.bad | (hit && count == '0);
    tok_out.nonzero <= tok_in.nonzero | (live && count_after != '0);
  end

endmodule

FILE: hw/rtl/media_header_page_tracker_core.sv
// ----------------------------------------------------------------------------
// Media header page tracker
// Follows the header pages of a multiplexed container and flags those to keep.
// ----------------------------------------------------------------------------
// Each input item summarizes one container page; each yields exactly one
// result item holding a forward flag and the phase after that page. The
// block first expects the single-packet beginning page of the main stream,
// then records the serial and declared header count of every data-stream
// beginning page in a row of MAX_STREAMS entry cells, until the main stream's
// end page arrives. After that each page is looked up by a token that walks
// the cell row one cell per cycle: matching entries are counted down, and the
// token gathers whether any count is still nonzero. Pages outside the header
// phase are finished at acceptance; a page in the header phase is finished
// when the token comes back from the end of the row. One item is in work at
// a time, and an item is taken only when the result register is empty or
// being emptied. Entry tables need no clearing after reset: the fill count
// marks which cells hold entries.
// ----------------------------------------------------------------------------
module media_header_page_tracker_core #(
  parameter int MAX_STREAMS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // [7:0] packet_total, [39:8] stream_serial, [103:40] magic_bytes,
  // [135:104] declared_headers
  input  logic [135:0] s_tdata,
  input  logic         s_tuser,   // begin_flag
  input  logic         s_tlast,   // end_flag
  output logic         m_tvalid,
  input  logic         m_tready,
  // [0] forward, [3:1] phase, [7:4] zero
  output logic [7:0]   m_tdata
);
  import mhpt_pkg::*;

  localparam int UW = $clog2(MAX_STREAMS + 1);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t              state;
  phase_t              phase_reg;
  logic [SERIAL_W-1:0] main_serial;
  logic [SERIAL_W-1:0] scan_serial;
  logic [UW-1:0]       used;
  logic                start;
  logic                out_fwd;
  phase_t              out_phase;

  // Unpacked input fields.
  logic [7:0]          packet_total;
  logic                begin_flag;
  logic                end_flag;
  logic [SERIAL_W-1:0] stream_serial;
  logic [63:0]         magic_bytes;
  logic [COUNT_W-1:0]  declared_headers;

  assign packet_total     = s_tdata[7:0];
  assign stream_serial    = s_tdata[39:8];
  assign magic_bytes      = s_tdata[103:40];
  assign declared_headers = s_tdata[135:104];
  assign begin_flag       = s_tuser;
  assign end_flag         = s_tlast;

  logic accept;
  logic main_page;
  logic data_page;
  logic table_full;

  assign s_tready   = (state == S_IDLE) && (!m_tvalid || m_tready);
  assign accept     = s_tvalid && s_tready;
  assign main_page  = packet_total == 8'd1 && begin_flag && magic_bytes == MAIN_TAG;
  assign data_page  = packet_total == 8'd1 && begin_flag && magic_bytes == DATA_TAG;
  assign table_full = used == UW'(MAX_STREAMS);

  // A data-stream beginning page appends an entry at the fill count.
  mhpt_wr_t wr;
  assign wr.en     = accept && phase_reg == PH_MAIN_BEGIN && data_page && !table_full;
  assign wr.serial = stream_serial;
  assign wr.count  = declared_headers;

  // Token chain through the entry cells.
  mhpt_tok_t tok [0:MAX_STREAMS];
  assign tok[0] = '{active: start, fwd: 1'b0, bad: 1'b0, nonzero: 1'b0};

  for (genvar k = 0; k < MAX_STREAMS; k++) begin : g_cell
    mhpt_cell #(
      .MAX_STREAMS (MAX_STREAMS),
      .IDX         (k)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .wr          (wr),
      .used        (used),
      .scan_serial (scan_serial),
      .tok_in      (tok[k]),
      .tok_out     (tok[k+1])
    );
  end

  mhpt_tok_t tok_end;
  assign tok_end = tok[MAX_STREAMS];

  // A result is loaded either by a page finished at acceptance or by the
  // scan token coming back from the end of the row.
  logic result_load;
  assign result_load = (accept && phase_reg != PH_MAIN_END) ||
                       (state == S_SCAN && tok_end.active);

  // Result of a page finished at acceptance, for the phases handled without a scan.
  phase_t ph_next;
  logic   fwd_next;

  always_comb begin
    ph_next  = phase_reg;
    fwd_next = 1'b0;
    unique case (phase_reg)
      PH_NOTHING: begin
        if (main_page) begin
          ph_next  = PH_MAIN_BEGIN;
          fwd_next = 1'b1;
        end else begin
          ph_next = PH_INVALID;
        end
      end
      PH_MAIN_BEGIN: begin
        if (data_page) begin
          if (!table_full) begin
            fwd_next = 1'b1;
          end else begin
            ph_next = PH_INVALID;
          end
        end else if (end_flag && stream_serial == main_serial) begin
          ph_next  = PH_MAIN_END;
          fwd_next = 1'b1;
        end else begin
          ph_next = PH_INVALID;
        end
      end
      default: begin
        // Header phase goes through the scan; later phases ignore the page.
      end
    endcase
  end

  // Phase after a scan: all counts at zero wins over a zero-count hit.
  phase_t ph_scan;
  always_comb begin
    priority if (!tok_end.nonzero) begin
      ph_scan = PH_ALL_HEADERS;
    end else if (tok_end.bad) begin
      ph_scan = PH_INVALID;
    end else begin
      ph_scan = phase_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      phase_reg   <= PH_NOTHING;
      main_serial <= '0;
      used        <= '0;
      start       <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      start <= accept && phase_reg == PH_MAIN_END;
      if (result_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (phase_reg == PH_MAIN_END) begin
              scan_serial <= stream_serial;
              state       <= S_SCAN;
            end else begin
              phase_reg <= ph_next;
              out_fwd   <= fwd_next;
              out_phase <= ph_next;
              if (phase_reg == PH_NOTHING && main_page) begin
                main_serial <= stream_serial;
              end
              if (wr.en) begin
                used <= used + UW'(1);
              end
            end
          end
        end
        S_SCAN: begin
          if (tok_end.active) begin
            phase_reg <= ph_scan;
            out_fwd   <= tok_end.fwd;
            out_phase <= ph_scan;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {4'b0000, out_phase, out_fwd};

  // The scan token only comes back while a scan is in progress.
  assert property (@(posedge clk) disable iff (rst)
    tok_end.active |-> state == S_SCAN)
    else $error("scan token returned outside a scan");

  // A scan is only launched from a page taken in the header phase.
  assert property (@(posedge clk) disable iff (rst)
    start |-> $past(accept) && $past(phase_reg) == PH_MAIN_END)
    else $error("scan started without a header phase page");

  // The fill count never passes the number of cells.
  assert property (@(posedge clk) disable iff (rst)
    used <= UW'(MAX_STREAMS))
    else $error("entry fill count overflow");

  // Entries are only appended while collecting data stream beginnings.
  assert property (@(posedge clk) disable iff (rst)
    used != $past(used) |-> $past(phase_reg) == PH_MAIN_BEGIN)
    else $error("entry appended outside the collection phase");

endmodule
